// ===== hw/rtl/hpts_pkg.sv =====
// Package for the heat-pump thermostat mode selector.
// Holds field widths, mode and register codes and the shared structs.
// Depends on nothing; every other file uses it.
`default_nettype none

package hpts_pkg;

    // Field widths
    localparam int TEMP_W  = 18;
    localparam int BAND_W  = 15;
    localparam int LIMIT_W = 8;
    localparam int COUNT_W = 16;
    localparam int MODE_W  = 2;
    localparam int DIFF_W  = TEMP_W + 2;

    // Configuration port widths
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Heat-pump modes
    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COOL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEAT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_HEAT2 = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAT_SP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOL_SP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_BAND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOOST_LIMIT = 3'd4;

    // Register reset values
    localparam logic signed [TEMP_W-1:0] HEAT_SP_RST     = 18'sd21111;
    localparam logic signed [TEMP_W-1:0] COOL_SP_RST     = 18'sd23888;
    localparam logic [BAND_W-1:0]        DEAD_BAND_RST   = 15'd500;
    localparam logic [BAND_W-1:0]        BOOST_BAND_RST  = 15'd1500;
    localparam logic [LIMIT_W-1:0]       BOOST_LIMIT_RST = 8'd20;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [TEMP_W-1:0] heat_setpoint;
        logic signed [TEMP_W-1:0] cool_setpoint;
        logic [BAND_W-1:0]        dead_band;
        logic [BAND_W-1:0]        boost_band;
        logic [LIMIT_W-1:0]       boost_count_limit;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [COUNT_W-1:0] count;
    } t_mode_state;

endpackage

`default_nettype wire

// ===== hw/rtl/hpts_ifs.sv =====
// Channel interfaces for the thermostat mode selector: sample, result, config.
// Each carries valid, ready and the payload; depends on hpts_pkg.
`default_nettype none

interface hpts_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [hpts_pkg::TEMP_W-1:0]  temperature;

    modport source (output valid, output temperature, input ready);
    modport sink   (input valid, input temperature, output ready);
endinterface

interface hpts_result_if;
    logic                         valid;
    logic                         ready;
    logic [hpts_pkg::MODE_W-1:0]  hvac_mode;
    logic [hpts_pkg::COUNT_W-1:0] same_mode_count;
    logic                         reversing_valve_level;
    logic                         compressor_level;
    logic                         emergency_heat_level;
    logic                         fan_level;

    modport source (output valid, output hvac_mode, output same_mode_count,
                    output reversing_valve_level, output compressor_level,
                    output emergency_heat_level, output fan_level, input ready);
    modport sink   (input valid, input hvac_mode, input same_mode_count,
                    input reversing_valve_level, input compressor_level,
                    input emergency_heat_level, input fan_level, output ready);
endinterface

interface hpts_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hpts_pkg::CFG_IDX_W-1:0]  index;
    logic [hpts_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/heat_pump_thermostat_mode_select.sv =====
// Heat-pump thermostat mode selector, top level.
// Usage:
//   i_sample carries one temperature word (millidegrees C, signed). Each word
//   gives exactly one word on o_result: the new mode (off, cool, heat,
//   stage-2 heat), the same-mode count and four relay pin levels.
//   i_cfg writes the five registers by index (heat setpoint, cool setpoint,
//   dead band, boost band, boost count limit) and drops unknown indexes. It
//   is always ready. Write it only while no sample is in flight (not enforced).
// Stages and throughput:
//   Two stages: an input register, then the mode/count state that doubles as
//   the result register. One sample per cycle is sustained while o_result is
//   ready; the decision for a sample uses the mode and count left by the one
//   before it, in the second stage.
// Reset:
//   Synchronous, active low: mode off, count zero, registers to defaults,
//   both stages empty.
// Stall:
//   While o_result is held, the result word stays put; one more sample is
//   taken into the input register, then i_sample.ready drops.
// Depends on hpts_pkg, hpts_ifs and hpts_mode_logic.
`default_nettype none

module heat_pump_thermostat_mode_select (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hpts_sample_if.sink i_sample,
    hpts_cfg_if.sink    i_cfg,
    hpts_result_if.source o_result
);
    import hpts_pkg::*;

    t_cfg                     r_cfg;
    logic                     r_in_valid;
    logic signed [TEMP_W-1:0] r_temp;
    logic                     r_out_valid;
    t_mode_state              r_state;
    t_mode_state              n_state;
    logic                     w_advance;
    logic                     w_take;

    // Write configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.heat_setpoint     <= HEAT_SP_RST;
            r_cfg.cool_setpoint     <= COOL_SP_RST;
            r_cfg.dead_band         <= DEAD_BAND_RST;
            r_cfg.boost_band        <= BOOST_BAND_RST;
            r_cfg.boost_count_limit <= BOOST_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_HEAT_SP:     r_cfg.heat_setpoint     <= signed'(i_cfg.data[TEMP_W-1:0]);
                REG_COOL_SP:     r_cfg.cool_setpoint     <= signed'(i_cfg.data[TEMP_W-1:0]);
                REG_DEAD_BAND:   r_cfg.dead_band         <= i_cfg.data[BAND_W-1:0];
                REG_BOOST_BAND:  r_cfg.boost_band        <= i_cfg.data[BAND_W-1:0];
                REG_BOOST_LIMIT: r_cfg.boost_count_limit <= i_cfg.data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance a sample into the result stage when that slot is free or leaving
    assign w_advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_in_valid || w_advance;
    assign w_take         = i_sample.valid && i_sample.ready;

    // Hold the accepted sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_temp <= i_sample.temperature;
        end
    end

    hpts_mode_logic u_mode_logic (
        .i_cfg         (r_cfg),
        .i_temperature (r_temp),
        .i_cur         (r_state),
        .o_next        (n_state)
    );

    // Update mode and count; they are also the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode  <= MODE_OFF;
            r_state.count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_advance) begin
                r_state <= n_state;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Drive result word; relay levels follow from the mode
    assign o_result.valid                 = r_out_valid;
    assign o_result.hvac_mode             = r_state.mode;
    assign o_result.same_mode_count       = r_state.count;
    assign o_result.reversing_valve_level = (r_state.mode != MODE_COOL);
    assign o_result.compressor_level      = (r_state.mode == MODE_OFF);
    assign o_result.emergency_heat_level  = (r_state.mode != MODE_HEAT2);
    assign o_result.fan_level             = (r_state.mode == MODE_OFF);

`ifndef SYNTHESIS
    // A mode change restarts the count
    a_change_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_state.mode != r_state.mode) |=> (r_state.count == '0))
        else $error("count not cleared on mode change");

    // An unchanged mode advances an unsaturated count by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_state.mode == r_state.mode && r_state.count != COUNT_MAX)
        |=> (r_state.count == $past(r_state.count) + COUNT_W'(1)))
        else $error("count did not advance");

    // State moves only when a sample advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state))
        else $error("state changed without a sample");

    // An empty input stage always takes a sample
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_sample.ready)
        else $error("input stage empty but not ready");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/hpts_mode_logic.sv =====
// Next-mode decision for one temperature sample: heat pass, then cool pass,
// then the saturating same-mode count. Combinational; depends on hpts_pkg.
`default_nettype none

module hpts_mode_logic (
    input  wire hpts_pkg::t_cfg                      i_cfg,
    input  wire logic signed [hpts_pkg::TEMP_W-1:0]  i_temperature,
    input  wire hpts_pkg::t_mode_state               i_cur,
    output hpts_pkg::t_mode_state                    o_next
);
    import hpts_pkg::*;

    logic signed [DIFF_W-1:0] w_d_heat;
    logic signed [DIFF_W-1:0] w_d_cool;
    logic signed [DIFF_W-1:0] w_db;
    logic signed [DIFF_W-1:0] w_bb;
    logic                     w_over_limit;
    logic [MODE_W-1:0]        w_heat_mode;
    logic [MODE_W-1:0]        w_cool_mode;
    logic [MODE_W-1:0]        w_mode;

    // Form the setpoint shortfalls and the bands at a common signed width
    assign w_d_heat = DIFF_W'(i_cfg.heat_setpoint) - DIFF_W'(i_temperature);
    assign w_d_cool = DIFF_W'(i_cfg.cool_setpoint) - DIFF_W'(i_temperature);
    assign w_db     = signed'({{(DIFF_W-BAND_W){1'b0}}, i_cfg.dead_band});
    assign w_bb     = signed'({{(DIFF_W-BAND_W){1'b0}}, i_cfg.boost_band});
    assign w_over_limit =
        i_cur.count > {{(COUNT_W-LIMIT_W){1'b0}}, i_cfg.boost_count_limit};

    // Heat pass against the low setpoint; cool counts as off
    always_comb begin
        w_heat_mode = (i_cur.mode == MODE_COOL) ? MODE_OFF : i_cur.mode;
        if (w_heat_mode != MODE_OFF) begin
            if (w_d_heat <= -w_db) begin
                w_heat_mode = MODE_OFF;
            end
            if (w_heat_mode == MODE_HEAT && (w_d_heat > w_bb || w_over_limit)) begin
                w_heat_mode = MODE_HEAT2;
            end
        end else if (w_d_heat > w_bb) begin
            w_heat_mode = MODE_HEAT2;
        end else if (w_d_heat > w_db) begin
            w_heat_mode = MODE_HEAT;
        end
    end

    // Cool pass against the high setpoint; either heat mode counts as off
    always_comb begin
        w_cool_mode = (i_cur.mode == MODE_COOL) ? MODE_COOL : MODE_OFF;
        if (w_cool_mode != MODE_OFF) begin
            if (w_d_cool >= w_db) begin
                w_cool_mode = MODE_OFF;
            end
        end else if (w_d_cool < -w_db) begin
            w_cool_mode = MODE_COOL;
        end
    end

    assign w_mode = (w_heat_mode == MODE_OFF) ? w_cool_mode : w_heat_mode;

    // Restart the count on a change, otherwise advance and saturate
    always_comb begin
        o_next.mode = w_mode;
        if (w_mode != i_cur.mode) begin
            o_next.count = '0;
        end else if (i_cur.count != COUNT_MAX) begin
            o_next.count = i_cur.count + COUNT_W'(1);
        end else begin
            o_next.count = i_cur.count;
        end
    end

endmodule

`default_nettype wire
